[rtl/iapp_pkg.sv]
// ----------------------------------------------------------------------------
// iapp_pkg
// Shared types and constants of the acknowledgement payload parser.
// ----------------------------------------------------------------------------
package iapp_pkg;

   localparam logic [31:0] CODEC_ID      = 32'h4F505553;
   localparam int          MIN_LEN       = 9;
   localparam int          DESC_LEN      = 1 + 1 + 4 + 2 + 1;
   localparam int          COUNT_W       = 12;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // positions inside one stream descriptor
   localparam logic [3:0] DP_ID     = 4'd0;
   localparam logic [3:0] DP_TYPE   = 4'd1;
   localparam logic [3:0] DP_CODEC0 = 4'd2;
   localparam logic [3:0] DP_CODEC1 = 4'd3;
   localparam logic [3:0] DP_CODEC2 = 4'd4;
   localparam logic [3:0] DP_CODEC3 = 4'd5;
   localparam logic [3:0] DP_DUR0   = 4'd6;
   localparam logic [3:0] DP_DUR1   = 4'd7;
   localparam logic [3:0] DP_ENABLE = 4'(DESC_LEN - 1);

   // register indexes of the control port
   localparam logic [1:0] CSR_OWN_VERSION     = 2'd0;
   localparam logic [1:0] CSR_OWN_MIN_VERSION = 2'd1;
   localparam logic [1:0] CSR_AUDIO_TYPE_CODE = 2'd2;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_SHORT   = 2'd1,
      ST_INCOMPAT = 2'd2,
      ST_TRUNC   = 2'd3
   } status_type;

   typedef struct packed {
      logic [31:0] own_version;
      logic [31:0] own_min_version;
      logic [7:0]  audio_type_code;
   } cfg_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] peer_version;
      logic [31:0] peer_min_version;
      logic        has_audio_stream;
      logic [7:0]  audio_stream_id;
      logic [15:0] frame_duration_ms;
      logic        audio_enabled;
   } result_type;

endpackage

[rtl/init_ack_payload_parser_top.sv]
// ----------------------------------------------------------------------------
// init_ack_payload_parser_top
// Acknowledgement payload parser: one payload byte per word in, one
// result word per payload out.
//
//   channel  dir  handshake            payload
//   req_     in   req_valid/req_stall  req_payload_byte, req_last_byte
//   rsp_     out  rsp_valid/rsp_stall  status, versions, audio descriptor
//   csr_     in   csr_wr_en            csr_index, csr_wdata
//
// One byte per cycle sustained. A byte passes an input register and the
// parse step; the result of a last byte is then loaded into the result register.
// Non-last bytes keep flowing while a result is stalled; a last byte waits
// in the input register until the result register is free.
// Synchronous reset clears the payload state and sets the registers to
// their defaults (audio type code 1).
// ----------------------------------------------------------------------------
module init_ack_payload_parser_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_payload_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_peer_version,
   output logic [31:0] rsp_peer_min_version,
   output logic        rsp_has_audio_stream,
   output logic [7:0]  rsp_audio_stream_id,
   output logic [15:0] rsp_frame_duration_ms,
   output logic        rsp_audio_enabled,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import iapp_pkg::*;

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       consume;
   logic       out_busy;
   logic       res_valid;
   result_type res;
   result_type rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_version     <= '0;
         cfg_ff.own_min_version <= '0;
         cfg_ff.audio_type_code <= 8'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_OWN_VERSION:     cfg_ff.own_version     <= csr_wdata;
            CSR_OWN_MIN_VERSION: cfg_ff.own_min_version <= csr_wdata;
            CSR_AUDIO_TYPE_CODE: cfg_ff.audio_type_code <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input register, refilled whenever its word moves on
   assign req_stall = in_valid_ff && !consume;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_byte_ff <= req_payload_byte;
         in_last_ff <= req_last_byte;
      end
   end

   iapp_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid_ff),
      .in_byte   (in_byte_ff),
      .in_last   (in_last_ff),
      .out_busy  (out_busy),
      .cfg       (cfg_ff),
      .consume   (consume),
      .res_valid (res_valid),
      .res       (res)
   );

   iapp_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (res_valid),
      .load_data  (res),
      .busy       (out_busy),
      .out_stall  (rsp_stall),
      .out_valid  (rsp_valid),
      .out_data   (rsp_data)
   );

   assign rsp_status            = rsp_data.status;
   assign rsp_peer_version      = rsp_data.peer_version;
   assign rsp_peer_min_version  = rsp_data.peer_min_version;
   assign rsp_has_audio_stream  = rsp_data.has_audio_stream;
   assign rsp_audio_stream_id   = rsp_data.audio_stream_id;
   assign rsp_frame_duration_ms = rsp_data.frame_duration_ms;
   assign rsp_audio_enabled     = rsp_data.audio_enabled;

endmodule

[rtl/iapp_core.sv]
// ----------------------------------------------------------------------------
// iapp_core
// Payload state and per-byte parse step; forms the result on the last byte.
// ----------------------------------------------------------------------------
module iapp_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [7:0]         in_byte,
   input  logic               in_last,
   input  logic               out_busy,
   input  iapp_pkg::cfg_type  cfg,
   output logic               consume,
   output logic               res_valid,
   output iapp_pkg::result_type res
);
   import iapp_pkg::*;

   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]        pv_ff, pv_in;
   logic [31:0]        pm_ff, pm_in;
   logic [7:0]         sl_ff, sl_in;
   logic [3:0]         dp_ff, dp_in;
   logic [7:0]         id_ff, id_in;
   logic [7:0]         type_ff, type_in;
   logic [31:0]        codec_ff, codec_in;
   logic [15:0]        dur_ff, dur_in;
   logic               ff_ff, ff_in;
   logic [7:0]         fid_ff, fid_in;
   logic [15:0]        fdur_ff, fdur_in;
   status_type         status;

   // a last byte may only go when the result register can take it
   assign consume   = in_valid && !(in_last && out_busy);
   assign res_valid = consume && in_last;

   always_comb begin
      cnt_in   = cnt_ff;
      pv_in    = pv_ff;
      pm_in    = pm_ff;
      sl_in    = sl_ff;
      dp_in    = dp_ff;
      id_in    = id_ff;
      type_in  = type_ff;
      codec_in = codec_ff;
      dur_in   = dur_ff;
      ff_in    = ff_ff;
      fid_in   = fid_ff;
      fdur_in  = fdur_ff;

      if (cnt_ff[COUNT_W-1:2] == '0) begin
         case (cnt_ff[1:0])
            2'd0: pv_in[7:0]   = in_byte;
            2'd1: pv_in[15:8]  = in_byte;
            2'd2: pv_in[23:16] = in_byte;
            default: pv_in[31:24] = in_byte;
         endcase
      end else if (cnt_ff[COUNT_W-1:3] == '0) begin
         case (cnt_ff[1:0])
            2'd0: pm_in[7:0]   = in_byte;
            2'd1: pm_in[15:8]  = in_byte;
            2'd2: pm_in[23:16] = in_byte;
            default: pm_in[31:24] = in_byte;
         endcase
      end else if (cnt_ff == COUNT_W'(MIN_LEN - 1)) begin
         sl_in = in_byte;
         dp_in = DP_ID;
      end else if (sl_ff != '0) begin
         dp_in = dp_ff + 4'd1;
         case (dp_ff)
            DP_ID:     id_in           = in_byte;
            DP_TYPE:   type_in         = in_byte;
            DP_CODEC0: codec_in[7:0]   = in_byte;
            DP_CODEC1: codec_in[15:8]  = in_byte;
            DP_CODEC2: codec_in[23:16] = in_byte;
            DP_CODEC3: codec_in[31:24] = in_byte;
            DP_DUR0:   dur_in[7:0]     = in_byte;
            DP_DUR1:   dur_in[15:8]    = in_byte;
            default: begin
               // enable byte closes the descriptor
               if (type_ff == cfg.audio_type_code && codec_ff == CODEC_ID
                   && in_byte != 8'd0) begin
                  ff_in   = 1'b1;
                  fid_in  = id_ff;
                  fdur_in = dur_ff;
               end
               sl_in = sl_ff - 8'd1;
               dp_in = DP_ID;
            end
         endcase
      end

      if (cnt_ff != COUNT_MAX) cnt_in = cnt_ff + 1'b1;
   end

   always_comb begin
      if (cnt_in < COUNT_W'(MIN_LEN)) begin
         status = ST_SHORT;
      end else if (pm_in > cfg.own_version || pv_in < cfg.own_min_version) begin
         status = ST_INCOMPAT;
      end else if (sl_in != '0) begin
         status = ST_TRUNC;
      end else begin
         status = ST_OK;
      end

      res = '0;
      res.status = status;
      if (status != ST_SHORT) begin
         res.peer_version     = pv_in;
         res.peer_min_version = pm_in;
      end
      if (status == ST_OK && ff_in) begin
         res.has_audio_stream  = 1'b1;
         res.audio_stream_id   = fid_in;
         res.frame_duration_ms = fdur_in;
         res.audio_enabled     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (consume && in_last)) begin
         cnt_ff   <= '0;
         pv_ff    <= '0;
         pm_ff    <= '0;
         sl_ff    <= '0;
         dp_ff    <= '0;
         id_ff    <= '0;
         type_ff  <= '0;
         codec_ff <= '0;
         dur_ff   <= '0;
         ff_ff    <= 1'b0;
         fid_ff   <= '0;
         fdur_ff  <= '0;
      end else if (consume) begin
         cnt_ff   <= cnt_in;
         pv_ff    <= pv_in;
         pm_ff    <= pm_in;
         sl_ff    <= sl_in;
         dp_ff    <= dp_in;
         id_ff    <= id_in;
         type_ff  <= type_in;
         codec_ff <= codec_in;
         dur_ff   <= dur_in;
         ff_ff    <= ff_in;
         fid_ff   <= fid_in;
         fdur_ff  <= fdur_in;
      end
   end

endmodule

[rtl/iapp_rsp_reg.sv]
// ----------------------------------------------------------------------------
// iapp_rsp_reg
// Result register in front of the response channel.
// ----------------------------------------------------------------------------
module iapp_rsp_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  iapp_pkg::result_type load_data,
   output logic                 busy,
   input  logic                 out_stall,
   output logic                 out_valid,
   output iapp_pkg::result_type out_data
);
   import iapp_pkg::*;

   logic       valid_ff;
   result_type data_ff;

   assign busy      = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!busy) begin
         valid_ff <= load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!busy && load_valid) begin
         data_ff <= load_data;
      end
   end

endmodule
